>>> src/sdrm_pkg.sv
`timescale 1ns / 1ps

package sdrm_pkg;

    // operand widths fixed by the item format
    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 63;
    localparam int MODE_W     = 2;

    // quotient bits produced per restoring step stage
    localparam int BITS_PER_STAGE = 4;

    // rounding mode codes
    typedef enum logic [MODE_W-1:0] {
        MODE_FLOOR   = 2'd0,
        MODE_CEIL    = 2'd1,
        MODE_NEAREST = 2'd2,
        MODE_RSVD    = 2'd3
    } mode_t;

    // side information carried alongside the division pipe
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              neg;
        logic              zero_div;
    } side_t;

endpackage

>>> src/sdrm_div_stage.sv
`timescale 1ns / 1ps

module sdrm_div_stage
    import sdrm_pkg::*;
#(
    parameter int STEPS = BITS_PER_STAGE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] in_quo,
    input  logic [DIVIDEND_W-1:0] in_rem,
    input  logic [DIVISOR_W-1:0]  in_dvs,
    input  side_t                 in_side,
    output logic                  out_valid,
    output logic [DIVIDEND_W-1:0] out_quo,
    output logic [DIVIDEND_W-1:0] out_rem,
    output logic [DIVISOR_W-1:0]  out_dvs,
    output side_t                 out_side
);

    logic                  valid_reg;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    side_t                 side_reg;

    // restoring steps: quo shifts out dividend bits at the top, in quotient bits at the bottom
    always_comb begin
        logic [DIVIDEND_W:0] trial;
        quo_next = in_quo;
        rem_next = in_rem;
        for (int i = 0; i < STEPS; i++) begin
            trial    = {rem_next, quo_next[DIVIDEND_W-1]} - {2'b00, in_dvs};
            quo_next = {quo_next[DIVIDEND_W-2:0], ~trial[DIVIDEND_W]};
            if (!trial[DIVIDEND_W]) begin
                rem_next = trial[DIVIDEND_W-1:0];
            end else begin
                rem_next = {rem_next[DIVIDEND_W-2:0], in_quo[DIVIDEND_W-1-i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= in_dvs;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_quo   = quo_reg;
    assign out_rem   = rem_reg;
    assign out_dvs   = dvs_reg;
    assign out_side  = side_reg;

endmodule

>>> src/sdrm_round.sv
`timescale 1ns / 1ps

module sdrm_round
    import sdrm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] in_quo,
    input  logic [DIVIDEND_W-1:0] in_rem,
    input  logic [DIVISOR_W-1:0]  in_dvs,
    input  side_t                 in_side,
    output logic                  out_valid,
    output logic [DIVIDEND_W-1:0] out_quo,
    output logic [DIVIDEND_W-1:0] out_rem,
    output logic                  out_err
);

    logic                  valid_a_reg, valid_b_reg;
    logic [DIVIDEND_W-1:0] qf_reg, qf_next;
    logic [DIVIDEND_W-1:0] rf_reg, rf_next;
    logic [DIVIDEND_W-1:0] dvs_reg;
    side_t                 side_reg;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVIDEND_W-1:0] r_reg, r_next;
    logic                  err_reg;
    logic [DIVIDEND_W-1:0] dvs_ext;
    logic                  bump;

    assign dvs_ext = {1'b0, in_dvs};

    // floor correction of the magnitude result
    always_comb begin
        if (!in_side.neg) begin
            qf_next = in_quo;
            rf_next = in_rem;
        end else if (in_rem == '0) begin
            qf_next = '0 - in_quo;
            rf_next = '0;
        end else begin
            qf_next = ~in_quo;
            rf_next = dvs_ext - in_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qf_reg   <= qf_next;
            rf_reg   <= rf_next;
            dvs_reg  <= dvs_ext;
            side_reg <= in_side;
        end
    end

    // mode adjustment, cleared to zero on a zero divisor
    always_comb begin
        unique case (mode_t'(side_reg.mode))
            MODE_FLOOR: bump = 1'b0;
            MODE_CEIL:  bump = (rf_reg != '0);
            default:    bump = ((dvs_reg - rf_reg) <= rf_reg);
        endcase
        q_next = bump ? qf_reg + 1'b1 : qf_reg;
        r_next = bump ? rf_reg - dvs_reg : rf_reg;
        if (side_reg.zero_div) begin
            q_next = '0;
            r_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_reg   <= q_next;
            r_reg   <= r_next;
            err_reg <= side_reg.zero_div;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (adv) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_quo   = q_reg;
    assign out_rem   = r_reg;
    assign out_err   = err_reg;

endmodule

>>> src/signed_divider_rounding_modes_core.sv
`timescale 1ns / 1ps

// Signed divider with floor, ceiling and nearest rounding. Takes one beat per
// cycle while the pipe is not stalled and returns one result beat per input
// beat, in order. The pipe is one input register, a chain of
// restoring-division stages each resolving STEP_BITS quotient bits, then two
// rounding stages. A zero divisor sets divide_error with zero quotient and
// remainder. Mode 3 acts as nearest.
module signed_divider_rounding_modes_core
    import sdrm_pkg::*;
#(
    parameter int STEP_BITS = BITS_PER_STAGE
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode [1:0], dividend [65:2], divisor [128:66], zero fill [135:129]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quotient [63:0], remainder [127:64], divide_error [128], zero fill [135:129]
    output logic [135:0] m_tdata
);

    localparam int NSTAGE = DIVIDEND_W / STEP_BITS;

    logic adv;
    logic out_valid;

    logic                  vld  [NSTAGE+1];
    logic [DIVIDEND_W-1:0] quo  [NSTAGE+1];
    logic [DIVIDEND_W-1:0] rem  [NSTAGE+1];
    logic [DIVISOR_W-1:0]  dvs  [NSTAGE+1];
    side_t                 side [NSTAGE+1];

    logic                  in_valid_reg;
    logic [DIVIDEND_W-1:0] mag_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    side_t                 side_reg;
    logic [DIVIDEND_W-1:0] dividend;

    logic [DIVIDEND_W-1:0] q_out, r_out;
    logic                  e_out;

    // stall the whole pipe only when a finished beat waits at the output
    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;

    assign dividend = s_tdata[MODE_W +: DIVIDEND_W];

    // input stage: magnitude of the dividend
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg       <= dividend[DIVIDEND_W-1] ? '0 - dividend : dividend;
            dvs_reg       <= s_tdata[MODE_W+DIVIDEND_W +: DIVISOR_W];
            side_reg.mode <= s_tdata[MODE_W-1:0];
            side_reg.neg  <= dividend[DIVIDEND_W-1];
            side_reg.zero_div <= (s_tdata[MODE_W+DIVIDEND_W +: DIVISOR_W] == '0);
        end
    end

    assign vld[0]  = in_valid_reg;
    assign quo[0]  = mag_reg;
    assign rem[0]  = '0;
    assign dvs[0]  = dvs_reg;
    assign side[0] = side_reg;

    // restoring division chain
    for (genvar g = 0; g < NSTAGE; g++) begin : g_div
        sdrm_div_stage #(
            .STEPS(STEP_BITS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (vld[g]),
            .in_quo    (quo[g]),
            .in_rem    (rem[g]),
            .in_dvs    (dvs[g]),
            .in_side   (side[g]),
            .out_valid (vld[g+1]),
            .out_quo   (quo[g+1]),
            .out_rem   (rem[g+1]),
            .out_dvs   (dvs[g+1]),
            .out_side  (side[g+1])
        );
    end

    // rounding and output register
    sdrm_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vld[NSTAGE]),
        .in_quo    (quo[NSTAGE]),
        .in_rem    (rem[NSTAGE]),
        .in_dvs    (dvs[NSTAGE]),
        .in_side   (side[NSTAGE]),
        .out_valid (out_valid),
        .out_quo   (q_out),
        .out_rem   (r_out),
        .out_err   (e_out)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'b0, e_out, r_out, q_out};

endmodule

>>> test/signed_divider_rounding_modes_core_test.sv
`timescale 1ns / 1ps

module signed_divider_rounding_modes_core_test;
    import sdrm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_DEPTH     = 19;
    localparam int RANDOM_ITEMS   = 1950;

    typedef struct packed {
        logic [63:0] quotient;
        logic [63:0] remainder;
        logic        divide_error;
    } div_result_t;

    typedef struct {
        mode_t       mode;
        logic [63:0] dividend;
        logic [62:0] divisor;
        logic        known;
        div_result_t result;
    } div_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;

    div_result_t expected_results[$];
    div_row_t    directed_rows[$];
    int          mismatch_count;
    int          result_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    bit          timed_out;

    signed_divider_rounding_modes_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // rounded division, exact over the full dividend range
    function automatic div_result_t divide_rounded(mode_t mode, logic [63:0] dividend,
                                                   logic [62:0] divisor);
        div_result_t res;
        logic [63:0] mag;
        logic [63:0] q_mag;
        logic [63:0] r_mag;
        logic [63:0] q_floor;
        logic [63:0] r_floor;
        logic [63:0] m;
        m = {1'b0, divisor};
        res = '0;
        if (divisor == '0) begin
            res.divide_error = 1'b1;
            return res;
        end
        mag = dividend[63] ? (64'd0 - dividend) : dividend;
        q_mag = mag / m;
        r_mag = mag % m;
        if (!dividend[63]) begin
            q_floor = q_mag;
            r_floor = r_mag;
        end else if (r_mag == '0) begin
            q_floor = 64'd0 - q_mag;
            r_floor = '0;
        end else begin
            q_floor = 64'd0 - (q_mag + 64'd1);
            r_floor = m - r_mag;
        end
        res.quotient = q_floor;
        res.remainder = r_floor;
        if (mode == MODE_CEIL) begin
            if (r_floor != '0) begin
                res.quotient = q_floor + 64'd1;
                res.remainder = r_floor - m;
            end
        end else if (mode == MODE_NEAREST || mode == MODE_RSVD) begin
            if (m - r_floor <= r_floor) begin
                res.quotient = q_floor + 64'd1;
                res.remainder = r_floor - m;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // divisors biased toward small and edge values
    function automatic logic [62:0] random_divisor();
        logic [62:0] d;
        case ($urandom_range(0, 9))
            0: d = '0;
            1: d = 63'd1;
            2: d = '1;
            3, 4: d = 63'($urandom_range(1, 20));
            5: d = 63'(random_word() >> $urandom_range(0, 62));
            default: d = 63'(random_word());
        endcase
        return d;
    endfunction

    function automatic logic [63:0] random_dividend();
        logic [63:0] x;
        case ($urandom_range(0, 7))
            0: x = 64'h8000_0000_0000_0000;
            1: x = 64'h7fff_ffff_ffff_ffff;
            2: x = 64'($signed($urandom_range(0, 40)) - 32'sd20);
            3: x = $signed(random_word()) >>> $urandom_range(0, 63);
            default: x = random_word();
        endcase
        return x;
    endfunction

    // send one beat and record its expected result
    task automatic send_division(mode_t mode, logic [63:0] dividend, logic [62:0] divisor,
                                 logic known, div_result_t typed_result);
        div_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        predicted = divide_rounded(mode, dividend, divisor);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, divisor, dividend, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(known ? typed_result : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_block(int count);
        for (int i = 0; i < count; i++)
            send_division(mode_t'($urandom_range(0, 3)), random_dividend(),
                          random_divisor(), 1'b0, '0);
    endtask

    // receiver stall and hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checking
    always @(posedge aclk) begin
        div_result_t actual;
        div_result_t wanted;
        if (aresetn && m_tvalid && m_tready) begin
            actual.quotient     = m_tdata[63:0];
            actual.remainder    = m_tdata[127:64];
            actual.divide_error = m_tdata[128];
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result beat q=%h r=%h err=%b",
                             actual.quotient, actual.remainder, actual.divide_error);
            end else begin
                wanted = expected_results.pop_front();
                if (actual !== wanted || m_tdata[135:129] !== 7'd0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: expected q=%h r=%h err=%b, got q=%h r=%h err=%b",
                                 wanted.quotient, wanted.remainder, wanted.divide_error,
                                 actual.quotient, actual.remainder, actual.divide_error);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("signed_divider_rounding_modes_core test failed");
            $finish;
        end
    end

    // directed table: typed results only for error, extreme and trivial rows
    initial begin
        div_row_t row;
        logic [63:0] min64;
        logic [63:0] max64;
        min64 = 64'h8000_0000_0000_0000;
        max64 = 64'h7fff_ffff_ffff_ffff;
        directed_rows = '{
            '{MODE_FLOOR,   64'd100,      63'd0, 1'b1, '{64'd0, 64'd0, 1'b1}},
            '{MODE_NEAREST, max64,        63'd0, 1'b1, '{64'd0, 64'd0, 1'b1}},
            '{MODE_FLOOR,   min64,        63'd1, 1'b1, '{min64, 64'd0, 1'b0}},
            '{MODE_CEIL,    min64,        63'd1, 1'b1, '{min64, 64'd0, 1'b0}},
            '{MODE_NEAREST, min64,        63'd1, 1'b1, '{min64, 64'd0, 1'b0}},
            '{MODE_RSVD,    min64,        63'd1, 1'b1, '{min64, 64'd0, 1'b0}},
            '{MODE_FLOOR,   max64,        63'd1, 1'b1, '{max64, 64'd0, 1'b0}},
            '{MODE_FLOOR,   64'd0,        '1,    1'b1, '{64'd0, 64'd0, 1'b0}},
            '{MODE_FLOOR,   -64'sd7,      63'd2, 1'b0, '0},
            '{MODE_CEIL,    -64'sd7,      63'd2, 1'b0, '0},
            '{MODE_NEAREST, -64'sd7,      63'd2, 1'b0, '0},
            '{MODE_NEAREST, 64'd7,        63'd2, 1'b0, '0},
            '{MODE_RSVD,    64'd5,        63'd10, 1'b0, '0},
            '{MODE_NEAREST, -64'sd5,      63'd10, 1'b0, '0},
            '{MODE_CEIL,    64'd7,        63'd3, 1'b0, '0},
            '{MODE_FLOOR,   min64,        '1,    1'b0, '0},
            '{MODE_CEIL,    min64,        '1,    1'b0, '0},
            '{MODE_NEAREST, min64,        '1,    1'b0, '0},
            '{MODE_NEAREST, max64,        '1,    1'b0, '0},
            '{MODE_CEIL,    max64,        63'd2, 1'b0, '0},
            '{MODE_NEAREST, 64'hffff_ffff_ffff_ffff, '1, 1'b0, '0},
            '{MODE_FLOOR,   64'h5555_5555_aaaa_aaaa, 63'h2aaa_aaaa_5555_5555, 1'b0, '0},
            '{MODE_CEIL,    64'haaaa_aaaa_5555_5555, 63'h5555_5555_aaaa_aaaa, 1'b0, '0}
        };
        mismatch_count = 0;
        result_count = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_division(row.mode, row.dividend, row.divisor, row.known, row.result);
        end

        // random phases with varied idling
        send_random_block(RANDOM_ITEMS / 5);
        send_idle_pct = 63;
        send_random_block(RANDOM_ITEMS / 5);
        send_idle_pct = 0;
        recv_stall_pct = 63;
        send_random_block(RANDOM_ITEMS / 5);
        send_idle_pct = 31;
        recv_stall_pct = 31;
        send_random_block(RANDOM_ITEMS / 5);

        // long receiver hold-off while the sender keeps pushing
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 200;
        send_random_block(60);
        // sender pauses until the pipe has drained
        wait_drained();
        send_random_block(RANDOM_ITEMS / 5 - 60);

        wait_drained();
        repeat (PIPE_DEPTH * 3) @(posedge aclk);
        $display("covered %0d directed and %0d random divisions, %0d results checked",
                 directed_rows.size(), RANDOM_ITEMS, result_count);
        $display("all rounding modes, zero divisors and extreme operands under mixed stalls");
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("signed_divider_rounding_modes_core test passed");
        else
            $display("signed_divider_rounding_modes_core test failed");
        $finish;
    end

endmodule
